// ----- hw/rtl/lkd_pkg.sv -----
// lkd_pkg: shared types and constants for the serial LED/key display controller.
// Used by lkd_step and led_key_display_serial_ctrl. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkd_pkg;

    // Default sizes of the display RAM and key scan bank
    localparam int RAM_BYTES_DEF = 16;
    localparam int KEY_BYTES_DEF = 4;

    // RAM pointer holds 0..16 (address commands load up to 15, increment stops at 16)
    localparam int PTR_W = 5;

    // Command kind, taken from bits 7:6 of the first byte of a frame
    localparam logic [1:0] CMD_DATA    = 2'b01;
    localparam logic [1:0] CMD_DISPLAY = 2'b10;
    localparam logic [1:0] CMD_ADDRESS = 2'b11;

    // Bit positions inside command bytes
    localparam int DATA_READ_BIT  = 1;
    localparam int DATA_FIXED_BIT = 2;
    localparam int DISP_ON_BIT    = 3;

    typedef enum logic [1:0] {
        FUNC_WRITE    = 2'd0,
        FUNC_READ     = 2'd1,
        FUNC_STROBE   = 2'd2,
        FUNC_KEY_LOAD = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_IGNORED    = 2'd1,
        ST_ADDR_RANGE = 2'd2,
        ST_READ_PAST  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_AUTO  = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_CMD    = 2'd0,
        PH_IGNORE = 2'd1,
        PH_DATA   = 2'd2,
        PH_READ   = 2'd3
    } phase_t;

    // Controller state that does not depend on the key bank size
    typedef struct packed {
        logic [PTR_W-1:0] pointer;
        mode_t            mode;
        phase_t           phase;
        logic             disp_on;
        logic [2:0]       level;
    } ctrl_state_t;

    // Per-transaction result fields (display settings come from the state)
    typedef struct packed {
        status_t    status;
        logic [7:0] read_data;
        logic       ram_written;
        logic [3:0] write_address;
        logic [7:0] write_value;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/led_key_display_serial_ctrl.sv -----
// Serial LED/key display controller, device side: one byte event per transaction.
// Latency: result is registered, valid the cycle after the input transaction.
// Throughput: one transaction per cycle; input stays ready while m_ready is high
// or the result register is empty. Reset (aresetn low, synchronous) clears all
// settings, the key bank and the frame state; no clearing pass is needed.
// Display RAM writes are reported on the result port (ram_written/address/value).
`timescale 1ns / 1ps
`default_nettype none

module led_key_display_serial_ctrl #(
    parameter int RAM_BYTES = lkd_pkg::RAM_BYTES_DEF,
    parameter int KEY_BYTES = lkd_pkg::KEY_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [7:0] s_data_byte,
    input  wire logic [1:0] s_key_slot,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic [7:0]      m_read_data,
    output logic            m_display_enabled,
    output logic [2:0]      m_brightness,
    output logic            m_ram_written,
    output logic [3:0]      m_write_address,
    output logic [7:0]      m_write_value
);

    localparam int KIDX_W = $clog2(KEY_BYTES + 1);
    localparam int KSEL_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    lkd_pkg::ctrl_state_t ctrl_reg, ctrl_next;
    logic [KIDX_W-1:0]    key_idx_reg, key_idx_next;
    logic [7:0]           key_bytes_reg [KEY_BYTES];
    logic                 key_wr_en;
    logic [7:0]           key_rd_data;
    lkd_pkg::result_t     result_next, result_reg;
    logic                 disp_on_reg, level_unused_dummy;
    logic [2:0]           level_reg;
    logic                 m_valid_reg;
    logic                 accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Key byte selected by the read index (only used while the index is in range)
    assign key_rd_data = key_bytes_reg[key_idx_reg[KSEL_W-1:0]];

    lkd_step #(
        .RAM_BYTES (RAM_BYTES),
        .KEY_BYTES (KEY_BYTES)
    ) u_step (
        .func         (s_func),
        .data_byte    (s_data_byte),
        .key_slot     (s_key_slot),
        .ctrl_cur     (ctrl_reg),
        .key_idx      (key_idx_reg),
        .key_rd_data  (key_rd_data),
        .ctrl_next    (ctrl_next),
        .key_idx_next (key_idx_next),
        .key_wr_en    (key_wr_en),
        .result       (result_next)
    );

    // Controller state and key bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.pointer <= '0;
            ctrl_reg.mode    <= lkd_pkg::MODE_AUTO;
            ctrl_reg.phase   <= lkd_pkg::PH_CMD;
            ctrl_reg.disp_on <= 1'b0;
            ctrl_reg.level   <= '0;
            key_idx_reg      <= '0;
            for (int i = 0; i < KEY_BYTES; i++) begin
                key_bytes_reg[i] <= '0;
            end
        end else if (accept) begin
            ctrl_reg    <= ctrl_next;
            key_idx_reg <= key_idx_next;
            if (key_wr_en) begin
                key_bytes_reg[s_key_slot[KSEL_W-1:0]] <= s_data_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg  <= result_next;
            disp_on_reg <= ctrl_next.disp_on;
            level_reg   <= ctrl_next.level;
        end
    end

    assign level_unused_dummy = 1'b0;

    assign m_valid           = m_valid_reg;
    assign m_status          = result_reg.status;
    assign m_read_data       = result_reg.read_data;
    assign m_display_enabled = disp_on_reg | level_unused_dummy;
    assign m_brightness      = level_reg;
    assign m_ram_written     = result_reg.ram_written;
    assign m_write_address   = result_reg.write_address;
    assign m_write_value     = result_reg.write_value;

    // Read index never runs past the key bank
    assert property (@(posedge aclk) disable iff (!aresetn)
        key_idx_reg <= KIDX_W'(KEY_BYTES))
        else $error("key read index beyond key bank");

    // A strobe always reopens the frame for a command with the read index cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func == lkd_pkg::FUNC_STROBE |=>
            ctrl_reg.phase == lkd_pkg::PH_CMD && key_idx_reg == '0)
        else $error("strobe did not reset frame state");

    // A RAM write is only reported with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ram_written |-> m_status == lkd_pkg::ST_OK)
        else $error("RAM write reported with error status");

    // Reads past the key bank return zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lkd_pkg::ST_READ_PAST |-> m_read_data == 8'd0)
        else $error("read past keys returned data");

endmodule

`default_nettype wire

// ----- hw/rtl/lkd_step.sv -----
// lkd_step: combinational decode of one byte event against the current state.
// Depends on lkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkd_step #(
    parameter int RAM_BYTES = lkd_pkg::RAM_BYTES_DEF,
    parameter int KEY_BYTES = lkd_pkg::KEY_BYTES_DEF,
    localparam int KIDX_W   = $clog2(KEY_BYTES + 1)
) (
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        data_byte,
    input  wire logic [1:0]        key_slot,
    input  wire lkd_pkg::ctrl_state_t ctrl_cur,
    input  wire logic [KIDX_W-1:0] key_idx,
    input  wire logic [7:0]        key_rd_data,
    output lkd_pkg::ctrl_state_t   ctrl_next,
    output logic [KIDX_W-1:0]      key_idx_next,
    output logic                   key_wr_en,
    output lkd_pkg::result_t       result
);

    logic [1:0] cmd_kind;
    logic       ptr_in_ram;
    logic       idx_in_keys;
    logic       slot_in_keys;

    assign cmd_kind     = data_byte[7:6];
    assign ptr_in_ram   = ctrl_cur.pointer < lkd_pkg::PTR_W'(RAM_BYTES);
    assign idx_in_keys  = key_idx < KIDX_W'(KEY_BYTES);
    assign slot_in_keys = {1'b0, key_slot} < 3'(KEY_BYTES);

    // Event decode and state update
    always_comb begin
        ctrl_next            = ctrl_cur;
        key_idx_next         = key_idx;
        key_wr_en            = 1'b0;
        result.status        = lkd_pkg::ST_OK;
        result.read_data     = '0;
        result.ram_written   = 1'b0;
        result.write_address = '0;
        result.write_value   = '0;

        case (lkd_pkg::func_t'(func))
            lkd_pkg::FUNC_WRITE: begin
                if (ctrl_cur.phase == lkd_pkg::PH_CMD) begin
                    // first byte of a frame is a command
                    case (cmd_kind)
                        lkd_pkg::CMD_DATA: begin
                            if (data_byte[lkd_pkg::DATA_READ_BIT]) begin
                                ctrl_next.mode  = lkd_pkg::MODE_READ;
                                ctrl_next.phase = lkd_pkg::PH_READ;
                                key_idx_next    = '0;
                            end else begin
                                ctrl_next.mode  = data_byte[lkd_pkg::DATA_FIXED_BIT] ?
                                                  lkd_pkg::MODE_FIXED : lkd_pkg::MODE_AUTO;
                                ctrl_next.phase = lkd_pkg::PH_IGNORE;
                            end
                        end
                        lkd_pkg::CMD_DISPLAY: begin
                            ctrl_next.disp_on = data_byte[lkd_pkg::DISP_ON_BIT];
                            ctrl_next.level   = data_byte[2:0];
                            ctrl_next.phase   = lkd_pkg::PH_IGNORE;
                        end
                        lkd_pkg::CMD_ADDRESS: begin
                            ctrl_next.pointer = {1'b0, data_byte[3:0]};
                            ctrl_next.phase   = lkd_pkg::PH_DATA;
                        end
                        default: begin
                            // unknown command: drop the rest of the frame
                            ctrl_next.phase = lkd_pkg::PH_IGNORE;
                            result.status   = lkd_pkg::ST_IGNORED;
                        end
                    endcase
                end else if (ctrl_cur.phase == lkd_pkg::PH_DATA &&
                             ctrl_cur.mode != lkd_pkg::MODE_READ) begin
                    if (ptr_in_ram) begin
                        result.ram_written   = 1'b1;
                        result.write_address = ctrl_cur.pointer[3:0];
                        result.write_value   = data_byte;
                        if (ctrl_cur.mode == lkd_pkg::MODE_AUTO) begin
                            ctrl_next.pointer = ctrl_cur.pointer + lkd_pkg::PTR_W'(1);
                        end
                    end else begin
                        result.status = lkd_pkg::ST_ADDR_RANGE;
                    end
                end else begin
                    result.status = lkd_pkg::ST_IGNORED;
                end
            end
            lkd_pkg::FUNC_READ: begin
                if (ctrl_cur.phase != lkd_pkg::PH_READ) begin
                    result.status = lkd_pkg::ST_IGNORED;
                end else if (idx_in_keys) begin
                    result.read_data = key_rd_data;
                    key_idx_next     = key_idx + KIDX_W'(1);
                end else begin
                    result.status = lkd_pkg::ST_READ_PAST;
                end
            end
            lkd_pkg::FUNC_STROBE: begin
                ctrl_next.phase = lkd_pkg::PH_CMD;
                key_idx_next    = '0;
            end
            default: begin
                // key bank load
                if (slot_in_keys) begin
                    key_wr_en = 1'b1;
                end else begin
                    result.status = lkd_pkg::ST_IGNORED;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
